/* src/ttgs_pkg.sv */
// Shared types and constants for the topic token Gibbs sampler.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package ttgs_pkg;

   // Token commands and result status codes.
   localparam logic CMD_ASSIGN      = 1'b0;
   localparam logic CMD_RESAMPLE    = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_TERM = 1'b1;

   // Register map of the configuration port.
   localparam int unsigned CSR_IW = 2;
   localparam int unsigned CSR_DW = 24;
   localparam logic [CSR_IW-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_BETA  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_VOCAB = 2'd2;

   localparam logic [23:0] ALPHA_RESET = 24'd65536;
   localparam logic [23:0] BETA_RESET  = 24'd6554;
   localparam logic [12:0] VOCAB_RESET = 13'd4096;

   // Count widths and saturation limits.
   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam logic [23:0] TOT_MAX = 24'hFFFFFF;

   // Ratio divider produces one quotient bit per step.
   localparam int unsigned RDIV_STEPS = 32;
   // The draw threshold is (draw + 1) / DRAW_SCALE.
   localparam int unsigned DRAW_SCALE = 1000;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_W_RD,
      ST_W_LOAD,
      ST_W_PRE,
      ST_W_DIV,
      ST_W_MUL,
      ST_W_ACC,
      ST_SCAN_PRE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_INC_RD,
      ST_INC_WR,
      ST_OUT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic clr_step;
      logic prep;
      logic k_zero;
      logic k_old;
      logic k_next;
      logic ab_load;
      logic div_init;
      logic div_step;
      logic mul;
      logic acc;
      logic scan_prep;
      logic scan_step;
      logic dec_we;
      logic inc_we;
      logic rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_done;
      logic term_bad;
      logic resample;
      logic old_ok;
      logic k_last;
      logic ratio_direct;
      logic div_last;
      logic hit;
   } dp_status_type;

endpackage

`default_nettype wire

/* src/ttgs_datapath.sv */
// Datapath of the topic token Gibbs sampler: count memories, weight buffer,
// bit-serial ratio divider, weight multiplier, draw scan and result register.
// Depends on ttgs_pkg.
`default_nettype none

module ttgs_datapath #(
   parameter int NUM_TOPICS = 16,
   parameter int NUM_DOCS   = 1024,
   parameter int VOCAB_MAX  = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [ttgs_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [ttgs_pkg::CSR_DW-1:0]   csr_data,
   input  wire logic                          req_command,
   input  wire logic [9:0]                    req_doc_index,
   input  wire logic [11:0]                   req_term_index,
   input  wire logic [3:0]                    req_old_topic,
   input  wire logic [9:0]                    req_random_draw,
   input  wire ttgs_pkg::dp_cmd_type          cmd,
   output ttgs_pkg::dp_status_type            status,
   output logic [3:0]                         rsp_new_topic,
   output logic                               rsp_status
);
   import ttgs_pkg::*;

   localparam int TW        = $clog2(NUM_TOPICS);
   localparam int DW        = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1;
   localparam int VW        = $clog2(VOCAB_MAX);
   localparam int DT_DEPTH  = NUM_DOCS * NUM_TOPICS;
   localparam int TT_DEPTH  = NUM_TOPICS * VOCAB_MAX;
   localparam int DTAW      = $clog2(DT_DEPTH);
   localparam int TTAW      = $clog2(TT_DEPTH);
   localparam int CLR_DEPTH = (DT_DEPTH > TT_DEPTH) ? DT_DEPTH : TT_DEPTH;
   localparam int CLRW      = $clog2(CLR_DEPTH + 1);
   localparam int SUMW      = 32 + TW;
   localparam int CMPW      = SUMW + 11;
   localparam int DENW      = 41;
   localparam int NUMW      = 33;

   // Reduce a document number modulo NUM_DOCS by restoring subtraction.
   function automatic logic [DW-1:0] doc_reduce(input logic [9:0] v);
      logic [20:0] acc;
      acc = {11'd0, v};
      if (NUM_DOCS < 1024) begin
         for (int j = 9; j >= 0; j--) begin
            if (acc >= (21'(NUM_DOCS) << j)) begin
               acc = acc - (21'(NUM_DOCS) << j);
            end
         end
      end
      return DW'(acc);
   endfunction

   function automatic logic [15:0] inc16(input logic [15:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

   function automatic logic [15:0] dec16(input logic [15:0] v);
      return (v == 16'd0) ? v : v - 16'd1;
   endfunction

   // Configuration registers.
   logic [23:0] alpha_ff, beta_ff;
   logic [12:0] vocab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
         vocab_ff <= VOCAB_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_data;
            CSR_BETA:  beta_ff  <= csr_data;
            CSR_VOCAB: vocab_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Token registers, loaded when a beat is accepted.
   logic        cmd_ff;
   logic [9:0]  doc_raw_ff;
   logic [11:0] term_ff;
   logic [3:0]  old_ff;
   logic [10:0] draw1_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff     <= req_command;
         doc_raw_ff <= req_doc_index;
         term_ff    <= req_term_index;
         old_ff     <= req_old_topic;
         draw1_ff   <= 11'(req_random_draw) + 11'd1;
      end
   end

   // Per-item preparation: reduced document and the beta times vocabulary term.
   logic [DW-1:0] d_ff;
   logic [36:0]   bv_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         d_ff  <= doc_reduce(doc_raw_ff);
         bv_ff <= 37'(beta_ff) * 37'(vocab_ff);
      end
   end

   logic [16:0]   limit;
   logic [VW-1:0] t_idx;
   assign limit = (17'(vocab_ff) < 17'(VOCAB_MAX)) ? 17'(vocab_ff) : 17'(VOCAB_MAX);
   assign t_idx = VW'(term_ff);

   // Topic pointer shared by the decrement, weight, scan and increment phases.
   logic [TW-1:0] k_ff;

   always_ff @(posedge clock) begin
      if (cmd.k_zero) begin
         k_ff <= '0;
      end else if (cmd.k_old) begin
         k_ff <= TW'(old_ff);
      end else if (cmd.k_next) begin
         k_ff <= k_ff + TW'(1);
      end
   end

   // Clearing sweep counter after reset.
   logic [CLRW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + CLRW'(1);
      end
   end

   // Memory addresses.
   logic [DTAW-1:0] dt_addr;
   logic [TTAW-1:0] tt_addr;
   assign dt_addr = DTAW'(d_ff) * DTAW'(NUM_TOPICS) + DTAW'(k_ff);
   assign tt_addr = TTAW'(k_ff) * TTAW'(VOCAB_MAX) + TTAW'(t_idx);

   // Document-topic counts.
   logic [15:0]     dt_mem [DT_DEPTH];
   logic [15:0]     dt_rd_ff;
   logic            dt_we;
   logic [DTAW-1:0] dt_wa;
   logic [15:0]     dt_wd;

   assign dt_we = (cmd.clr_step && (clr_ff < CLRW'(DT_DEPTH))) || cmd.dec_we || cmd.inc_we;
   assign dt_wa = cmd.clr_step ? clr_ff[DTAW-1:0] : dt_addr;
   assign dt_wd = cmd.clr_step ? 16'd0 : (cmd.dec_we ? dec16(dt_rd_ff) : inc16(dt_rd_ff));

   always_ff @(posedge clock) begin
      if (dt_we) begin
         dt_mem[dt_wa] <= dt_wd;
      end
      dt_rd_ff <= dt_mem[dt_addr];
   end

   // Term-topic counts.
   logic [15:0]     tt_mem [TT_DEPTH];
   logic [15:0]     tt_rd_ff;
   logic            tt_we;
   logic [TTAW-1:0] tt_wa;
   logic [15:0]     tt_wd;

   assign tt_we = (cmd.clr_step && (clr_ff < CLRW'(TT_DEPTH))) || cmd.dec_we || cmd.inc_we;
   assign tt_wa = cmd.clr_step ? clr_ff[TTAW-1:0] : tt_addr;
   assign tt_wd = cmd.clr_step ? 16'd0 : (cmd.dec_we ? dec16(tt_rd_ff) : inc16(tt_rd_ff));

   always_ff @(posedge clock) begin
      if (tt_we) begin
         tt_mem[tt_wa] <= tt_wd;
      end
      tt_rd_ff <= tt_mem[tt_addr];
   end

   // Topic totals.
   logic [23:0]   tot_mem [NUM_TOPICS];
   logic [23:0]   tot_rd_ff;
   logic          tot_we;
   logic [TW-1:0] tot_wa;
   logic [23:0]   tot_wd;

   assign tot_we = (cmd.clr_step && (clr_ff < CLRW'(NUM_TOPICS))) || cmd.dec_we || cmd.inc_we;
   assign tot_wa = cmd.clr_step ? clr_ff[TW-1:0] : k_ff;
   always_comb begin
      if (cmd.clr_step) begin
         tot_wd = 24'd0;
      end else if (cmd.dec_we) begin
         tot_wd = (tot_rd_ff == 24'd0) ? tot_rd_ff : tot_rd_ff - 24'd1;
      end else begin
         tot_wd = (tot_rd_ff == TOT_MAX) ? tot_rd_ff : tot_rd_ff + 24'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_wa] <= tot_wd;
      end
      tot_rd_ff <= tot_mem[k_ff];
   end

   // Document totals, counted on assign only.
   logic [15:0]   dtot_mem [NUM_DOCS];
   logic [15:0]   dtot_rd_ff;
   logic          dtot_we;
   logic [DW-1:0] dtot_wa;
   logic [15:0]   dtot_wd;

   assign dtot_we = (cmd.clr_step && (clr_ff < CLRW'(NUM_DOCS)))
                  || (cmd.inc_we && (cmd_ff == CMD_ASSIGN));
   assign dtot_wa = cmd.clr_step ? clr_ff[DW-1:0] : d_ff;
   assign dtot_wd = cmd.clr_step ? 16'd0 : inc16(dtot_rd_ff);

   always_ff @(posedge clock) begin
      if (dtot_we) begin
         dtot_mem[dtot_wa] <= dtot_wd;
      end
      dtot_rd_ff <= dtot_mem[d_ff];
   end

   // Weight operands: A and B numerators and the denominator D.
   logic [NUMW-1:0] a_ff;
   logic [DENW-1:0] den_ff;
   logic [24:0]     bs_ff;
   logic [NUMW-1:0] b_full;

   assign b_full = NUMW'({dt_rd_ff, 16'h0}) + NUMW'(alpha_ff);

   always_ff @(posedge clock) begin
      if (cmd.ab_load) begin
         a_ff   <= NUMW'({tt_rd_ff, 16'h0}) + NUMW'(beta_ff);
         den_ff <= DENW'({tot_rd_ff, 16'h0}) + DENW'(bv_ff);
         bs_ff  <= b_full[32:8];
      end
   end

   // Bit-serial ratio divider: R = (A << 16) / D, saturated to 32 bits.
   logic            den_zero, ratio_sat;
   logic [DENW-1:0] rem_ff;
   logic [31:0]     nlo_ff;
   logic [31:0]     ratio_ff;
   logic [4:0]      div_cnt_ff;
   logic [DENW:0]   rem_sh;
   logic            q_bit;

   assign den_zero  = (den_ff == '0);
   assign ratio_sat = {24'd0, a_ff} >= {den_ff, 16'h0};
   assign rem_sh    = {rem_ff, nlo_ff[31]};
   assign q_bit     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         if (den_zero && (a_ff == '0)) begin
            ratio_ff <= 32'd0;
         end else if (ratio_sat) begin
            ratio_ff <= 32'hFFFF_FFFF;
         end else begin
            ratio_ff <= 32'd0;
         end
         rem_ff     <= DENW'(a_ff[32:16]);
         nlo_ff     <= {a_ff[15:0], 16'h0};
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= q_bit ? DENW'(rem_sh - {1'b0, den_ff}) : DENW'(rem_sh);
         nlo_ff     <= {nlo_ff[30:0], 1'b0};
         ratio_ff   <= {ratio_ff[30:0], q_bit};
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end
   end

   // Weight product and accumulation of the weight total.
   logic [56:0]     prod_ff;
   logic [31:0]     w_sat;
   logic [SUMW-1:0] sum_ff;

   assign w_sat = (|prod_ff[56:40]) ? 32'hFFFF_FFFF : prod_ff[39:8];

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= 57'(ratio_ff) * 57'(bs_ff);
      end
      if (cmd.prep) begin
         sum_ff <= '0;
      end else if (cmd.acc) begin
         sum_ff <= sum_ff + SUMW'(w_sat);
      end
   end

   // Weight buffer, written in full before the scan reads it.
   logic [31:0] wb_mem [NUM_TOPICS];
   logic [31:0] wb_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc) begin
         wb_mem[k_ff] <= w_sat;
      end
      wb_rd_ff <= wb_mem[k_ff];
   end

   // Draw scan: first topic whose scaled running value reaches the threshold.
   logic [CMPW-1:0] rsum_ff;
   logic [SUMW-1:0] cum_ff;
   logic [SUMW-1:0] cum_next;
   logic [CMPW-1:0] rs_res, rs_asg, scan_val, scan_lhs;

   assign rs_res   = CMPW'(draw1_ff) * CMPW'(sum_ff);
   assign rs_asg   = CMPW'(draw1_ff) * CMPW'(NUM_TOPICS);
   assign cum_next = cum_ff + SUMW'(wb_rd_ff);
   assign scan_val = (cmd_ff == CMD_RESAMPLE) ? CMPW'(cum_next) : CMPW'(k_ff) + CMPW'(1);
   assign scan_lhs = scan_val * CMPW'(DRAW_SCALE);

   always_ff @(posedge clock) begin
      if (cmd.scan_prep) begin
         rsum_ff <= (cmd_ff == CMD_RESAMPLE) ? rs_res : rs_asg;
         cum_ff  <= '0;
      end else if (cmd.scan_step) begin
         cum_ff  <= cum_next;
      end
   end

   // Result register.
   logic [3:0] rsp_topic_ff;
   logic       rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_topic_ff  <= status.term_bad ? 4'd0 : 4'(k_ff);
         rsp_status_ff <= status.term_bad ? STATUS_BAD_TERM : STATUS_OK;
      end
   end

   assign rsp_new_topic = rsp_topic_ff;
   assign rsp_status    = rsp_status_ff;

   // Status towards the controller.
   assign status.clr_done     = (clr_ff == CLRW'(CLR_DEPTH));
   assign status.term_bad     = (17'(term_ff) >= limit);
   assign status.resample     = (cmd_ff == CMD_RESAMPLE);
   assign status.old_ok       = (9'(old_ff) < 9'(NUM_TOPICS));
   assign status.k_last       = (k_ff == TW'(NUM_TOPICS - 1));
   assign status.ratio_direct = den_zero || ratio_sat;
   assign status.div_last     = (div_cnt_ff == 5'(RDIV_STEPS - 1));
   assign status.hit          = (scan_lhs >= rsum_ff);

endmodule

`default_nettype wire

/* src/ttgs_ctrl.sv */
// Controller of the topic token Gibbs sampler: sequences the clearing sweep,
// count updates, weight loop and draw scan, and owns both handshakes. Uses ttgs_pkg.
`default_nettype none

module ttgs_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire ttgs_pkg::dp_status_type   status,
   output ttgs_pkg::dp_cmd_type           cmd
);
   import ttgs_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // State register and result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (status.clr_done) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.term_bad) begin
               state_in = ST_OUT;
            end else if (!status.resample) begin
               state_in = ST_SCAN_PRE;
            end else if (status.old_ok) begin
               state_in = ST_DEC_RD;
            end else begin
               state_in = ST_W_RD;
            end
         end
         ST_DEC_RD:   state_in = ST_DEC_WR;
         ST_DEC_WR:   state_in = ST_W_RD;
         ST_W_RD:     state_in = ST_W_LOAD;
         ST_W_LOAD:   state_in = ST_W_PRE;
         ST_W_PRE:    state_in = status.ratio_direct ? ST_W_MUL : ST_W_DIV;
         ST_W_DIV:    if (status.div_last) state_in = ST_W_MUL;
         ST_W_MUL:    state_in = ST_W_ACC;
         ST_W_ACC:    state_in = status.k_last ? ST_SCAN_PRE : ST_W_RD;
         ST_SCAN_PRE: state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = (status.hit || status.k_last) ? ST_INC_RD : ST_SCAN_RD;
         ST_INC_RD:   state_in = ST_INC_WR;
         ST_INC_WR:   state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // Datapath commands for each state.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR:    cmd.clr_step = !status.clr_done;
         ST_IDLE:     cmd.latch = req_valid;
         ST_CHECK: begin
            cmd.prep   = 1'b1;
            cmd.k_old  = status.resample && status.old_ok;
            cmd.k_zero = !(status.resample && status.old_ok);
         end
         ST_DEC_RD:   ;
         ST_DEC_WR: begin
            cmd.dec_we = 1'b1;
            cmd.k_zero = 1'b1;
         end
         ST_W_RD:     ;
         ST_W_LOAD:   cmd.ab_load = 1'b1;
         ST_W_PRE:    cmd.div_init = 1'b1;
         ST_W_DIV:    cmd.div_step = 1'b1;
         ST_W_MUL:    cmd.mul = 1'b1;
         ST_W_ACC: begin
            cmd.acc    = 1'b1;
            cmd.k_next = !status.k_last;
         end
         ST_SCAN_PRE: begin
            cmd.scan_prep = 1'b1;
            cmd.k_zero    = 1'b1;
         end
         ST_SCAN_RD:  ;
         ST_SCAN_CMP: begin
            cmd.scan_step = 1'b1;
            cmd.k_next    = !status.hit && !status.k_last;
         end
         ST_INC_RD:   ;
         ST_INC_WR:   cmd.inc_we = 1'b1;
         ST_OUT:      cmd.rsp_load = out_free;
         default:     ;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* src/topic_token_gibbs_sampler.sv */
// Top level of the topic token Gibbs sampler.
// Joins ttgs_ctrl and ttgs_datapath; uses ttgs_pkg.
//
// Use: each req_ beat is one token (command, document, term, old topic, draw).
// Each token gives exactly one rsp_ beat with the chosen topic and a status.
// Configuration is written through the csr_ channel, which is always ready,
// and should only be written while no token is in flight.
// Reset starts a clearing sweep through the count memories; req_ready stays
// low until it ends.
// Tokens are taken one at a time. An assign goes from the check straight to
// the draw scan, which steps through the topics up to the chosen one, and then
// to the count increment. A resample first decrements the old topic's counts
// (skipped when the old topic is out of range), then runs a weight loop over
// all topics: a read, load, set-up, the bit-serial ratio divider, 32 steps per
// topic, a multiply and an accumulate; then it scans and increments.
// A topic whose ratio saturates or whose denominator is zero skips the divider.
// A rejected term goes from the check straight to its result.
// The result sits in an output register; while the receiver stalls the next
// token is accepted and worked on, and waits at the end for the register.
`default_nettype none

module topic_token_gibbs_sampler #(
   parameter int NUM_TOPICS = 16,
   parameter int NUM_DOCS   = 1024,
   parameter int VOCAB_MAX  = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_command,
   input  wire logic [9:0]                    req_doc_index,
   input  wire logic [11:0]                   req_term_index,
   input  wire logic [3:0]                    req_old_topic,
   input  wire logic [9:0]                    req_random_draw,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [3:0]                         rsp_new_topic,
   output logic                               rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ttgs_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [ttgs_pkg::CSR_DW-1:0]   csr_data
);
   import ttgs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   ttgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttgs_datapath #(
      .NUM_TOPICS (NUM_TOPICS),
      .NUM_DOCS   (NUM_DOCS),
      .VOCAB_MAX  (VOCAB_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_command     (req_command),
      .req_doc_index   (req_doc_index),
      .req_term_index  (req_term_index),
      .req_old_topic   (req_old_topic),
      .req_random_draw (req_random_draw),
      .cmd             (cmd),
      .status          (status),
      .rsp_new_topic   (rsp_new_topic),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

/* src/ttgs_chk.sv */
// Port checker for the topic token Gibbs sampler, bound to the top level.
// Uses ttgs_pkg for the status codes.
`default_nettype none

module ttgs_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_new_topic,
   input wire logic       rsp_status
);
   import ttgs_pkg::*;

   // No token is taken in the cycle after reset: the clearing sweep runs first.
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready high straight after reset");

   // Tokens are worked one at a time: an accepted beat closes the input.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again right after a beat");

   // A rejected term reports topic zero.
   a_bad_term_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_BAD_TERM)) |-> (rsp_new_topic == 4'd0))
      else $error("rejected term with nonzero topic");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_new_topic) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind topic_token_gibbs_sampler ttgs_chk u_ttgs_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_new_topic (rsp_new_topic),
   .rsp_status    (rsp_status)
);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the topic token Gibbs sampler count-table engine.
// Needs ttgs_pkg and topic_token_gibbs_sampler; holds its own count tables to predict
// each chosen topic, then drives a directed table followed by random token traffic.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import ttgs_pkg::*;

   localparam int TOPICS     = 16;
   localparam int DOCS       = 1024;
   localparam int TERMS      = 4096;
   localparam int N_RANDOM   = 1700;
   localparam int IDLE_LIMIT = 300000;
   localparam int LONG_HOLD  = 2000;
   localparam int DRAIN      = 800;

   typedef enum {ROW_TOKEN, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic              cmd;
      logic [9:0]        doc;
      logic [11:0]       term;
      logic [3:0]        old;
      logic [9:0]        draw;
      logic [CSR_IW-1:0] reg_index;
      logic [23:0]       reg_data;
      bit                typed;
      logic [3:0]        exp_topic;
      logic              exp_status;
   } stim_row_type;

   typedef struct {
      logic [3:0] topic;
      logic       status;
   } topic_result_type;

   typedef struct {
      logic [9:0]  doc;
      logic [11:0] term;
      logic [3:0]  topic;
   } live_token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = CMD_ASSIGN;
   logic [9:0] req_doc_index = '0;
   logic [11:0] req_term_index = '0;
   logic [3:0] req_old_topic = '0;
   logic [9:0] req_random_draw = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_new_topic;
   logic rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IW-1:0] csr_index = CSR_ALPHA;
   logic [CSR_DW-1:0] csr_data = '0;

   // Predictor state: count tables and register copies.
   logic [15:0] doc_topic_cnt [DOCS][TOPICS];
   logic [15:0] term_topic_cnt [TOPICS][TERMS];
   logic [23:0] topic_tot [TOPICS];
   logic [15:0] doc_tot [DOCS];
   logic [23:0] cfg_alpha = ALPHA_RESET;
   logic [23:0] cfg_beta = BETA_RESET;
   logic [12:0] cfg_vocab = VOCAB_RESET;

   topic_result_type pending_topics [$];
   live_token_type live_tokens [$];

   int errors = 0;
   int n_results = 0;
   int n_assign = 0;
   int n_resample = 0;
   int n_rejected = 0;
   int n_cfg = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 10;
   bit quiet = 1'b0;
   bit long_hold_done = 1'b0;

   topic_token_gibbs_sampler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_doc_index(req_doc_index),
      .req_term_index(req_term_index), .req_old_topic(req_old_topic),
      .req_random_draw(req_random_draw),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_topic(rsp_new_topic), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int d = 0; d < DOCS; d++) begin
         doc_tot[d] = '0;
         for (int k = 0; k < TOPICS; k++) doc_topic_cnt[d][k] = '0;
      end
      for (int k = 0; k < TOPICS; k++) begin
         topic_tot[k] = '0;
         for (int t = 0; t < TERMS; t++) term_topic_cnt[k][t] = '0;
      end
   end

   // Collapsed conditional weight of one topic, in Q16.16.
   function automatic logic [31:0] topic_weight(int d, int t, int k);
      logic [63:0] a, den, b, r, w;
      a = (64'(term_topic_cnt[k][t]) << 16) + 64'(cfg_beta);
      den = (64'(topic_tot[k]) << 16) + 64'(cfg_beta) * 64'(cfg_vocab);
      b = (64'(doc_topic_cnt[d][k]) << 16) + 64'(cfg_alpha);
      if (den == 0) begin
         r = (a == 0) ? 64'd0 : 64'hFFFF_FFFF;
      end else begin
         r = (a << 16) / den;
         if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      end
      w = (r * (b >> 8)) >> 8;
      if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
      return w[31:0];
   endfunction

   // Works out the chosen topic of one token and updates the count tables.
   function automatic topic_result_type sample_topic(logic cmd, logic [9:0] doc,
         logic [11:0] term, logic [3:0] old, logic [9:0] draw);
      topic_result_type res;
      int d, t, k, lim;
      logic [63:0] r1, sum, cum;
      logic [31:0] w [TOPICS];
      d = int'(doc) % DOCS;
      t = int'(term);
      r1 = 64'(draw) + 1;
      lim = (int'(cfg_vocab) < TERMS) ? int'(cfg_vocab) : TERMS;
      k = TOPICS - 1;
      if (t >= lim) begin
         res.topic = '0;
         res.status = STATUS_BAD_TERM;
         return res;
      end
      if (cmd == CMD_ASSIGN) begin
         for (int i = 0; i < TOPICS; i++) begin
            if (r1 * TOPICS <= 64'(1000 * (i + 1))) begin
               k = i;
               break;
            end
         end
         if (doc_tot[d] != CNT_MAX) doc_tot[d]++;
      end else begin
         if (int'(old) < TOPICS) begin
            if (doc_topic_cnt[d][old] != 0) doc_topic_cnt[d][old]--;
            if (term_topic_cnt[old][t] != 0) term_topic_cnt[old][t]--;
            if (topic_tot[old] != 0) topic_tot[old]--;
         end
         sum = 0;
         cum = 0;
         for (int i = 0; i < TOPICS; i++) begin
            w[i] = topic_weight(d, t, i);
            sum += 64'(w[i]);
         end
         for (int i = 0; i < TOPICS; i++) begin
            cum += 64'(w[i]);
            if (1000 * cum >= r1 * sum) begin
               k = i;
               break;
            end
         end
      end
      if (doc_topic_cnt[d][k] != CNT_MAX) doc_topic_cnt[d][k]++;
      if (term_topic_cnt[k][t] != CNT_MAX) term_topic_cnt[k][t]++;
      if (topic_tot[k] != TOT_MAX) topic_tot[k]++;
      res.topic = 4'(k);
      res.status = STATUS_OK;
      return res;
   endfunction

   // Offers one token beat; valid is only lowered when a gap is taken.
   task automatic send_token(logic cmd, logic [9:0] doc, logic [11:0] term,
         logic [3:0] old, logic [9:0] draw, output topic_result_type res);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_doc_index <= doc;
      req_term_index <= term;
      req_old_topic <= old;
      req_random_draw <= draw;
      do @(posedge clock); while (!req_ready);
      res = sample_topic(cmd, doc, term, old, draw);
      if (res.status == STATUS_BAD_TERM) n_rejected++;
      else if (cmd == CMD_ASSIGN) n_assign++;
      else n_resample++;
   endtask

   // Register write once every result is in and the block has settled.
   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [23:0] value);
      req_valid <= 1'b0;
      while (pending_topics.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ALPHA: cfg_alpha = value;
         CSR_BETA:  cfg_beta = value;
         CSR_VOCAB: cfg_vocab = value[12:0];
         default: ;
      endcase
      n_cfg++;
   endtask

   function automatic logic [23:0] pick_prior(logic [23:0] dflt);
      case ($urandom_range(0, 4))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return dflt;
         3: return 24'($urandom_range(0, 24'h3FFFF));
         default: return 24'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   // Directed table: extremes, rejected terms, zero priors and a single-term vocabulary.
   stim_row_type directed_rows [] = '{
      '{ROW_TOKEN, CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_ALPHA, 24'd0,
        1'b1, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_ASSIGN,   10'd1023, 12'd4095, 4'd0,  10'd998,  CSR_ALPHA, 24'd0,
        1'b1, 4'd15, STATUS_OK},
      '{ROW_TOKEN, CMD_ASSIGN,   10'd5,    12'd7,    4'd0,  10'd1023, CSR_ALPHA, 24'd0,
        1'b1, 4'd15, STATUS_OK},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd0,    12'd0,    4'd0,  10'd0,    CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd1023, 12'd4095, 4'd15, 10'd1023, CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd3,    12'd3,    4'd15, 10'd500,  CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_VOCAB, 24'd100,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_ASSIGN,   10'd4,    12'd100,  4'd0,  10'd10,   CSR_ALPHA, 24'd0,
        1'b1, 4'd0,  STATUS_BAD_TERM},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd4,    12'd4095, 4'd2,  10'd10,   CSR_ALPHA, 24'd0,
        1'b1, 4'd0,  STATUS_BAD_TERM},
      '{ROW_TOKEN, CMD_ASSIGN,   10'd9,    12'd99,   4'd0,  10'd600,  CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_BETA,  24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd9,    12'd9,    4'd0,  10'd400,  CSR_ALPHA, 24'd0,
        1'b1, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd0,    12'd0,    4'd0,  10'd998,  CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_ALPHA, 24'hFFFFFF,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_BETA,  24'hFFFFFF,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_VOCAB, 24'd1,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_ASSIGN,   10'd2,    12'd0,    4'd0,  10'd499,  CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_RESAMPLE, 10'd2,    12'd0,    4'd7,  10'd250,  CSR_ALPHA, 24'd0,
        1'b0, 4'd0,  STATUS_OK},
      '{ROW_TOKEN, CMD_ASSIGN,   10'd2,    12'd1,    4'd0,  10'd250,  CSR_ALPHA, 24'd0,
        1'b1, 4'd0,  STATUS_BAD_TERM},
      '{ROW_CSR,   CMD_ASSIGN,   10'd0,    12'd0,    4'd0,  10'd0,    CSR_VOCAB, 24'd4096,
        1'b0, 4'd0,  STATUS_OK}
   };

   // Stimulus: directed table, then random phases of token traffic, mostly well-formed with some noise.
   initial begin
      topic_result_type res;
      live_token_type tok;
      logic cmd;
      logic [9:0] doc, draw;
      logic [11:0] term;
      logic [3:0] old;
      int pick, lim, slot;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
         end else begin
            send_token(directed_rows[i].cmd, directed_rows[i].doc, directed_rows[i].term,
                       directed_rows[i].old, directed_rows[i].draw, res);
            if (directed_rows[i].typed) begin
               res.topic = directed_rows[i].exp_topic;
               res.status = directed_rows[i].exp_status;
            end
            pending_topics.push_back(res);
         end
      end
      write_reg(CSR_ALPHA, ALPHA_RESET);
      write_reg(CSR_BETA, BETA_RESET);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n > 0 && n % 350 == 0) begin
            write_reg(CSR_ALPHA, pick_prior(ALPHA_RESET));
            write_reg(CSR_BETA, pick_prior(BETA_RESET));
            case ($urandom_range(0, 3))
               0: write_reg(CSR_VOCAB, 24'd1);
               1: write_reg(CSR_VOCAB, 24'd4096);
               2: write_reg(CSR_VOCAB, 24'($urandom_range(1, 40)));
               default: write_reg(CSR_VOCAB, 24'($urandom_range(1, 4096)));
            endcase
            sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         end
         quiet = (n >= N_RANDOM - 150);
         lim = (int'(cfg_vocab) < TERMS) ? int'(cfg_vocab) : TERMS;
         pick = $urandom_range(0, 99);
         draw = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(999, 1023))
                                              : 10'($urandom_range(0, 998));
         if (pick < 30 || live_tokens.size() == 0) begin
            // New token on a small set of documents and terms, so counts pile up.
            cmd = CMD_ASSIGN;
            doc = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
            term = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, lim - 1))
                 : 12'($urandom_range(0, ((lim < 24) ? lim : 24) - 1));
            old = 4'($urandom);
            send_token(cmd, doc, term, old, draw, res);
            if (res.status == STATUS_OK && live_tokens.size() < 96) begin
               tok.doc = doc;
               tok.term = term;
               tok.topic = res.topic;
               live_tokens.push_back(tok);
            end
         end else if (pick < 88) begin
            // Resample a live token with the topic it holds.
            slot = $urandom_range(0, live_tokens.size() - 1);
            tok = live_tokens[slot];
            send_token(CMD_RESAMPLE, tok.doc, tok.term, tok.topic, draw, res);
            if (res.status == STATUS_OK) live_tokens[slot].topic = res.topic;
         end else begin
            // Noise: any field values, including stale topics and rejected terms.
            cmd = 1'($urandom);
            doc = 10'($urandom);
            term = 12'($urandom);
            old = 4'($urandom);
            draw = 10'($urandom);
            send_token(cmd, doc, term, old, draw, res);
         end
         pending_topics.push_back(res);
      end
      req_valid <= 1'b0;

      while (pending_topics.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("Covered %0d assigns, %0d resamples, %0d rejected terms, %0d register writes.",
               n_assign, n_resample, n_rejected, n_cfg);
      $display("Results checked: %0d, mismatches: %0d.", n_results, errors);
      if (errors == 0 && pending_topics.size() == 0)
         $display("[topic_token_gibbs_sampler] OK");
      else
         $display("[topic_token_gibbs_sampler] ERROR");
      $finish;
   end

   // Receiver back-pressure: short random bursts and one long hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (!long_hold_done && n_results >= 300) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: each beat against the oldest expectation.
   always @(posedge clock) begin
      topic_result_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_topics.size() == 0) begin
            $display("%0t: result beat with nothing expected, topic %0d status %0d",
                     $time, rsp_new_topic, rsp_status);
            errors++;
         end else begin
            exp = pending_topics.pop_front();
            if (rsp_new_topic !== exp.topic) begin
               $display("%0t: new_topic expected %0d actual %0d", $time, exp.topic,
                        rsp_new_topic);
               errors++;
            end
            if (rsp_status !== exp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
         $display("[topic_token_gibbs_sampler] ERROR");
         $finish;
      end
   end

endmodule

`default_nettype wire

/* topic_token_gibbs_sampler.f */
src/ttgs_pkg.sv
src/ttgs_datapath.sv
src/ttgs_ctrl.sv
src/topic_token_gibbs_sampler.sv
src/ttgs_chk.sv
verif/tb_top.sv
